// ===== rtl/splr_pkg.sv =====
// splr_pkg: shared constants, types and channel scaling helpers for the
// scanline palette pixel render unit. No dependencies.
`default_nettype none

package splr_pkg;

	localparam int LINE_COUNT = 200;
	localparam int LC_AW = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;

	localparam int PAL_BANKS = 4;
	localparam int PAL_BANK_DEPTH = 64;
	localparam int PAL_BANK_AW = 6;

	localparam int CLEAR_LEN = (LINE_COUNT > PAL_BANK_DEPTH) ? LINE_COUNT : PAL_BANK_DEPTH;
	localparam int CLR_AW = $clog2(CLEAR_LEN);

	localparam logic [9:0] PAL_BASE = 10'h100;
	localparam logic [9:0] PAL_END = 10'h300;

	localparam int CTRL_BIT_640 = 7;
	localparam int CTRL_BIT_FILL = 5;

	localparam int CFG_AW = 3;
	localparam logic REG_COLOR_SCALE = 1'b0;
	localparam logic [4:0] COLOR_SCALE_RESET = 5'd17;

	typedef enum logic {
		REQ_WRITE = 1'b0,
		REQ_RENDER = 1'b1
	} req_t;

	// palette colour: red nibble 11:8, green 7:4, blue 3:0
	typedef logic [11:0] colour_t;
	typedef logic [23:0] pixel_t;

	typedef struct packed {
		logic lo_en;
		logic hi_en;
		logic [PAL_BANK_AW-1:0] addr;
		logic [7:0] data;
	} pal_wr_t;

	function automatic logic [7:0] scale_nib(input logic [3:0] nib, input logic [4:0] sc);
		logic [8:0] prod;
		prod = 9'(nib) * 9'(sc);
		return (prod > 9'd255) ? 8'hFF : prod[7:0];
	endfunction

	function automatic pixel_t expand_colour(input colour_t c, input logic [4:0] sc);
		return {scale_nib(c[11:8], sc), scale_nib(c[7:4], sc), scale_nib(c[3:0], sc)};
	endfunction

endpackage

`default_nettype wire

// ===== rtl/splr_pal_bank.sv =====
// splr_pal_bank: one quarter of the palette, 64 colours, byte-lane writes and
// two registered read ports. Depends on splr_pkg.
`default_nettype none

module splr_pal_bank (
	input  wire logic                            clk,
	input  wire splr_pkg::pal_wr_t               wr,
	input  wire logic                            rd_en,
	input  wire logic [splr_pkg::PAL_BANK_AW-1:0] rd_addr_a,
	input  wire logic [splr_pkg::PAL_BANK_AW-1:0] rd_addr_b,
	output splr_pkg::colour_t                    rd_data_a,
	output splr_pkg::colour_t                    rd_data_b
);
	import splr_pkg::*;

	logic [7:0] lo_mem [PAL_BANK_DEPTH];
	logic [3:0] hi_mem [PAL_BANK_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.lo_en) begin
			lo_mem[wr.addr] <= wr.data;
		end
		if (wr.hi_en) begin
			hi_mem[wr.addr] <= wr.data[3:0];
		end
		if (rd_en) begin
			rd_data_a <= {hi_mem[rd_addr_a], lo_mem[rd_addr_a]};
			rd_data_b <= {hi_mem[rd_addr_b], lo_mem[rd_addr_b]};
		end
	end

endmodule

`default_nettype wire

// ===== rtl/scanline_palette_pixel_render_unit.sv =====
// scanline_palette_pixel_render_unit: top level, line control store, fill
// colour, render pipeline, output skid and config port.
// Depends on splr_pkg and splr_pal_bank.
//
// Usage: one request channel (in_valid/in_ready) carries write and render
// requests. A write request updates a line control byte or a palette byte and
// gives no result. A render request gives one result of four 24-bit pixels on
// the output channel (out_valid/out_ready).
// Throughput is one request per cycle while in_ready is high. A render
// request passes the line control read, then the palette read from the four
// 2-port palette banks, then channel scaling into the output register.
// Each of these steps is registered.
// After reset the block clears the line store and palette banks, stepping
// through CLEAR_LEN addresses (200 with the default line count); in_ready
// stays low until it is done. color_scale resets to 17 and may be written
// over the config port at any time, including during the clearing pass.
// When the receiver stalls, one extra result is parked in a skid register and
// in_ready drops the cycle after; the pipeline holds and nothing is lost.
`default_nettype none

module scanline_palette_pixel_render_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         req_type,
	input  wire logic [9:0]                   write_offset,
	input  wire logic [7:0]                   write_data,
	input  wire logic [7:0]                   scan_line,
	input  wire logic [7:0]                   column,
	input  wire logic [7:0]                   pixel_byte,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [23:0]                       pixel_0,
	output logic [23:0]                       pixel_1,
	output logic [23:0]                       pixel_2,
	output logic [23:0]                       pixel_3,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [splr_pkg::CFG_AW-1:0]  paddr,
	input  wire logic [31:0]                  pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);
	import splr_pkg::*;

	logic              clearing_q;
	logic [CLR_AW-1:0] clr_cnt_q;
	logic [4:0]        color_scale_q;

	logic en;
	logic in_fire;
	logic is_write;

	// line control store
	logic [7:0]       lc_mem [LINE_COUNT];
	logic             lc_we;
	logic [LC_AW-1:0] lc_waddr;
	logic [7:0]       lc_wdata;

	// palette write decode
	logic       pal_hit;
	logic [8:0] pal_off;

	pal_wr_t                pal_wr    [PAL_BANKS];
	logic [PAL_BANK_AW-1:0] rd_addr_a [PAL_BANKS];
	logic [PAL_BANK_AW-1:0] rd_addr_b;
	colour_t                rd_data_a [PAL_BANKS];
	colour_t                rd_data_b [PAL_BANKS];

	// stage 1
	logic       valid_s1;
	logic [7:0] ctrl_s1;
	logic       line_oor_s1;
	logic       col_zero_s1;
	logic [7:0] pix_s1;

	logic [7:0] ctrl;
	logic       mode640;
	logic       fill_en;
	logic [3:0] pal;
	logic [3:0] fill_q;
	logic [3:0] fill0;
	logic [3:0] fill1;
	logic [3:0] fill_next;
	logic [3:0] nib_a;
	logic [3:0] nib_b;

	// stage 2
	logic       valid_s2;
	logic       mode640_s2;
	logic [1:0] bank_a_s2;
	logic [1:0] bank_b_s2;

	pixel_t res [4];
	logic   push;

	// output and skid
	logic   out_valid_q;
	logic   skid_valid_q;
	pixel_t out_pix_q  [4];
	pixel_t skid_pix_q [4];

	assign en       = !skid_valid_q;
	assign in_ready = en && !clearing_q;
	assign in_fire  = in_valid && in_ready;
	assign is_write = (req_type == REQ_WRITE);

	// config port
	assign pready = 1'b1;
	assign prdata = (paddr[CFG_AW-1] == REG_COLOR_SCALE) ? 32'(color_scale_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_scale_q <= COLOR_SCALE_RESET;
		end else if (psel && penable && pwrite && paddr[CFG_AW-1] == REG_COLOR_SCALE) begin
			color_scale_q <= pwdata[4:0];
		end
	end

	// clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			if (clr_cnt_q == CLR_AW'(CLEAR_LEN - 1)) begin
				clearing_q <= 1'b0;
			end else begin
				clr_cnt_q <= clr_cnt_q + CLR_AW'(1);
			end
		end
	end

	always_comb begin
		if (clearing_q) begin
			lc_we    = (int'(clr_cnt_q) < LINE_COUNT);
			lc_waddr = clr_cnt_q[LC_AW-1:0];
			lc_wdata = '0;
		end else begin
			lc_we    = in_fire && is_write && (write_offset < 10'(LINE_COUNT));
			lc_waddr = write_offset[LC_AW-1:0];
			lc_wdata = write_data;
		end
	end

	always_ff @(posedge clk) begin
		if (lc_we) begin
			lc_mem[lc_waddr] <= lc_wdata;
		end
		if (en) begin
			ctrl_s1 <= lc_mem[scan_line[LC_AW-1:0]];
		end
	end

	assign pal_off = 9'(write_offset - PAL_BASE);
	assign pal_hit = in_fire && is_write && (write_offset >= PAL_BASE) && (write_offset < PAL_END);

	// stage 1 payload, valid bits and fill colour
	always_ff @(posedge clk) begin
		if (en) begin
			line_oor_s1 <= ({1'b0, scan_line} >= 9'(LINE_COUNT));
			col_zero_s1 <= (column == 8'd0);
			pix_s1      <= pixel_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			fill_q   <= '0;
		end else if (en) begin
			valid_s1 <= in_fire && (req_type == REQ_RENDER);
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				fill_q <= fill_next;
			end
		end
	end

	// mode, palette and fill colour resolution
	always_comb begin
		ctrl      = line_oor_s1 ? 8'd0 : ctrl_s1;
		mode640   = ctrl[CTRL_BIT_640];
		fill_en   = ctrl[CTRL_BIT_FILL];
		pal       = ctrl[3:0];
		fill0     = col_zero_s1 ? 4'd0 : fill_q;

		if (fill_en && pix_s1[7:4] == 4'd0) begin
			nib_a = fill0;
			fill1 = fill0;
		end else begin
			nib_a = pix_s1[7:4];
			fill1 = pix_s1[7:4];
		end

		if (fill_en && pix_s1[3:0] == 4'd0) begin
			nib_b     = fill1;
			fill_next = fill1;
		end else begin
			nib_b     = pix_s1[3:0];
			fill_next = pix_s1[3:0];
		end

		if (mode640) begin
			fill_next = fill0;
		end
	end

	assign rd_addr_b = {pal, nib_b[1:0]};

	for (genvar k = 0; k < PAL_BANKS; k++) begin : g_bank
		assign rd_addr_a[k] = mode640 ? {pal, pix_s1[2*(PAL_BANKS-1-k)+1 : 2*(PAL_BANKS-1-k)]}
		                              : {pal, nib_a[1:0]};

		always_comb begin
			pal_wr[k].addr  = clearing_q ? clr_cnt_q[PAL_BANK_AW-1:0]
			                             : {pal_off[8:5], pal_off[2:1]};
			pal_wr[k].data  = clearing_q ? 8'd0 : write_data;
			pal_wr[k].lo_en = clearing_q || (pal_hit && pal_off[4:3] == 2'(k) && !pal_off[0]);
			pal_wr[k].hi_en = clearing_q || (pal_hit && pal_off[4:3] == 2'(k) && pal_off[0]);
		end

		splr_pal_bank u_bank (
			.clk       (clk),
			.wr        (pal_wr[k]),
			.rd_en     (en),
			.rd_addr_a (rd_addr_a[k]),
			.rd_addr_b (rd_addr_b),
			.rd_data_a (rd_data_a[k]),
			.rd_data_b (rd_data_b[k])
		);
	end

	// stage 2 select info
	always_ff @(posedge clk) begin
		if (en) begin
			mode640_s2 <= mode640;
			bank_a_s2  <= nib_a[3:2];
			bank_b_s2  <= nib_b[3:2];
		end
	end

	always_comb begin
		if (mode640_s2) begin
			for (int i = 0; i < 4; i++) begin
				res[i] = expand_colour(rd_data_a[i], color_scale_q);
			end
		end else begin
			res[0] = expand_colour(rd_data_a[bank_a_s2], color_scale_q);
			res[1] = res[0];
			res[2] = expand_colour(rd_data_b[bank_b_s2], color_scale_q);
			res[3] = res[2];
		end
	end

	assign push = en && valid_s2;

	// output register with one skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_ready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !out_ready) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_ready) begin
				out_pix_q <= skid_pix_q;
			end
		end else if (push) begin
			if (out_valid_q && !out_ready) begin
				skid_pix_q <= res;
			end else begin
				out_pix_q <= res;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_0   = out_pix_q[0];
	assign pixel_1   = out_pix_q[1];
	assign pixel_2   = out_pix_q[2];
	assign pixel_3   = out_pix_q[3];

endmodule

`default_nettype wire
